// ===== hw/rtl/pcbd_pkg.sv =====
// shared types, constants and helpers for the pulse-count backlight dimmer
`default_nettype none
package pcbd_pkg;

   localparam int LEVELS_DEFAULT = 32;
   localparam int LEVEL_W        = 6;
   localparam int TIMER_W        = 12;
   localparam int CSR_DATA_W     = 12;
   localparam int CSR_IDX_W      = 2;

   // opcodes of an input beat
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_UPDATE  = 2'd1;
   localparam logic [1:0] OP_SUSPEND = 2'd2;
   localparam logic [1:0] OP_RESUME  = 2'd3;

   // status codes of a result beat
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SUSP  = 2'd2;
   localparam logic [1:0] ST_BUSY  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP_HIGH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_LOW      = 2'd3;

   // register reset values
   localparam logic [9:0]  PULSE_LOW_RESET    = 10'd10;
   localparam logic [9:0]  PULSE_HIGH_RESET   = 10'd10;
   localparam logic [11:0] STARTUP_HIGH_RESET = 12'd250;
   localparam logic [9:0]  OFF_LOW_RESET      = 10'd10;

   typedef struct packed {
      logic [9:0]  pulse_low;
      logic [9:0]  pulse_high;
      logic [11:0] startup_high;
      logic [9:0]  off_low;
   } cfg_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] level;
      logic       power_on;
      logic       unblank;
   } item_type;

   typedef struct packed {
      logic       pin_level;
      logic       busy_res;
      logic [1:0] status;
   } result_type;

   // a zero tick count behaves as one tick
   function automatic logic [TIMER_W-1:0] at_least_one(input logic [TIMER_W-1:0] v);
      return (v == '0) ? TIMER_W'(1) : v;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pcbd_if.sv =====
// request and response channel interfaces
`default_nettype none
interface pcbd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] level;
   logic       power_on;
   logic       unblank;

   modport source (output valid, opcode, level, power_on, unblank, input ready);
   modport sink   (input valid, opcode, level, power_on, unblank, output ready);
endinterface

interface pcbd_rsp_if;
   logic       valid;
   logic       ready;
   logic       pin_level;
   logic       busy_res;
   logic [1:0] status;

   modport source (output valid, pin_level, busy_res, status, input ready);
   modport sink   (input valid, pin_level, busy_res, status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pcbd_csr.sv =====
// timing registers written through the csr port
`default_nettype none
module pcbd_csr
   import pcbd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PULSE_LOW:    cfg_in.pulse_low    = csr_wdata[9:0];
            CSR_PULSE_HIGH:   cfg_in.pulse_high   = csr_wdata[9:0];
            CSR_STARTUP_HIGH: cfg_in.startup_high = csr_wdata[11:0];
            CSR_OFF_LOW:      cfg_in.off_low      = csr_wdata[9:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_low    <= PULSE_LOW_RESET;
         cfg_ff.pulse_high   <= PULSE_HIGH_RESET;
         cfg_ff.startup_high <= STARTUP_HIGH_RESET;
         cfg_ff.off_low      <= OFF_LOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/pcbd_core.sv =====
// dimming sequencer state and its single-pass update for one beat
`default_nettype none
module pcbd_core
   import pcbd_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output result_type    result
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_OFF,
      PH_START,
      PH_PLOW,
      PH_PHIGH
   } phase_type;

   localparam logic [LEVEL_W:0] LEVELS_V   = (LEVEL_W+1)'(LEVELS);
   localparam logic [7:0]       LEVELS_MAX = 8'(LEVELS);

   phase_type            phase_ff, phase_in;
   logic [LEVEL_W-1:0]   applied_ff, applied_in;
   logic [LEVEL_W-1:0]   requested_ff, requested_in;
   logic                 suspended_ff, suspended_in;
   logic [LEVEL_W-1:0]   pulses_ff, pulses_in;
   logic [TIMER_W-1:0]   timer_ff, timer_in;
   logic                 pin_ff, pin_in;

   always_comb begin
      logic               busy;
      logic [TIMER_W-1:0] timer_dec;
      logic [7:0]         lv8;
      logic               apply_en;
      logic [LEVEL_W-1:0] apply_lv;
      logic               sp_en;
      logic [LEVEL_W-1:0] sp_pulses;
      logic [1:0]         status;

      busy         = (phase_ff != PH_IDLE);
      timer_dec    = (timer_ff != '0) ? timer_ff - 1'b1 : '0;
      lv8          = (item.power_on && item.unblank) ? item.level : 8'd0;
      apply_en     = 1'b0;
      apply_lv     = '0;
      sp_en        = 1'b0;
      sp_pulses    = '0;
      status       = ST_OK;
      phase_in     = phase_ff;
      applied_in   = applied_ff;
      requested_in = requested_ff;
      suspended_in = suspended_ff;
      pulses_in    = pulses_ff;
      timer_in     = timer_ff;
      pin_in       = pin_ff;

      case (item.opcode)
         OP_TICK: begin
            if (busy) begin
               if (timer_dec != '0) begin
                  timer_in = timer_dec;
               end else begin
                  timer_in = '0;
                  case (phase_ff)
                     PH_OFF: begin
                        phase_in = PH_IDLE;
                        pin_in   = 1'b0;
                     end
                     PH_START: begin
                        sp_en     = 1'b1;
                        sp_pulses = pulses_ff;
                     end
                     PH_PLOW: begin
                        phase_in = PH_PHIGH;
                        pin_in   = 1'b1;
                        timer_in = at_least_one(TIMER_W'(cfg.pulse_high));
                     end
                     PH_PHIGH: begin
                        sp_en     = 1'b1;
                        sp_pulses = (pulses_ff != '0) ? pulses_ff - 1'b1 : '0;
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
         end
         OP_UPDATE: begin
            if (lv8 > LEVELS_MAX) begin
               status = ST_RANGE;
            end else begin
               requested_in = lv8[LEVEL_W-1:0];
               if (suspended_ff && lv8 != 8'd0) begin
                  status = ST_SUSP;
               end else if (busy) begin
                  status = ST_BUSY;
               end else begin
                  apply_en = 1'b1;
                  apply_lv = lv8[LEVEL_W-1:0];
               end
            end
         end
         OP_SUSPEND: begin
            pulses_in    = '0;
            phase_in     = PH_OFF;
            pin_in       = 1'b0;
            timer_in     = at_least_one(TIMER_W'(cfg.off_low));
            applied_in   = '0;
            suspended_in = 1'b1;
         end
         OP_RESUME: begin
            suspended_in = 1'b0;
            if (busy) begin
               status = ST_BUSY;
            end else begin
               apply_en = 1'b1;
               apply_lv = requested_ff;
            end
         end
         default: status = ST_OK;
      endcase

      if (apply_en) begin
         if (apply_lv == '0) begin
            pulses_in  = '0;
            phase_in   = PH_OFF;
            pin_in     = 1'b0;
            timer_in   = at_least_one(TIMER_W'(cfg.off_low));
            applied_in = '0;
         end else begin
            if (applied_ff == '0) begin
               // turning on from off: long high phase first
               pulses_in = LEVEL_W'(LEVELS_V - {1'b0, apply_lv});
               phase_in  = PH_START;
               pin_in    = 1'b1;
               timer_in  = at_least_one(cfg.startup_high);
            end else begin
               // downward distance, wrapping around the level count
               sp_en = 1'b1;
               if (apply_lv <= applied_ff)
                  sp_pulses = applied_ff - apply_lv;
               else
                  sp_pulses = LEVEL_W'(LEVELS_V - {1'b0, apply_lv - applied_ff});
            end
            applied_in = apply_lv;
         end
      end

      if (sp_en) begin
         pulses_in = sp_pulses;
         if (sp_pulses != '0) begin
            phase_in = PH_PLOW;
            pin_in   = 1'b0;
            timer_in = at_least_one(TIMER_W'(cfg.pulse_low));
         end else begin
            phase_in = PH_IDLE;
            pin_in   = 1'b1;
            timer_in = '0;
         end
      end

      result.pin_level = pin_in;
      result.busy_res  = (phase_in != PH_IDLE);
      result.status    = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         applied_ff   <= '0;
         requested_ff <= '0;
         suspended_ff <= 1'b0;
         pulses_ff    <= '0;
         timer_ff     <= '0;
         pin_ff       <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         applied_ff   <= applied_in;
         requested_ff <= requested_in;
         suspended_ff <= suspended_in;
         pulses_ff    <= pulses_in;
         timer_ff     <= timer_in;
         pin_ff       <= pin_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pulse_count_backlight_dimmer.sv =====
// top level of the pulse-count backlight dimmer: input register, sequencer, result register
//
//   channel   direction  handshake          payload
//   req_bus   in         valid/ready        opcode, level, power_on, unblank
//   rsp_bus   out        valid/ready        pin_level, busy_res, status
//   csr       in         csr_we, no stall   csr_index, csr_wdata
//
// one beat in, one beat out; a new beat is taken every cycle while the response side does not stall
// a beat passes through the input register, then the sequencer update into the result register
// the input register refills in the same cycle a result beat leaves, so a stall on the
// response side holds at most one beat in each register before req ready drops
// reset is synchronous and puts the pin low, the sequencer idle and timings at defaults
`default_nettype none
module pulse_count_backlight_dimmer
   import pcbd_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pcbd_req_if.sink                   req_bus,
   pcbd_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff;
   result_type result;
   result_type result_ff;
   logic       result_valid_ff;
   logic       advance;
   logic       req_fire;

   assign advance  = item_valid_ff && (!result_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !item_valid_ff || advance;
   assign req_fire = req_bus.valid && req_bus.ready;

   assign item_in.opcode   = req_bus.opcode;
   assign item_in.level    = req_bus.level;
   assign item_in.power_on = req_bus.power_on;
   assign item_in.unblank  = req_bus.unblank;

   pcbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcbd_core #(
      .LEVELS (LEVELS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready)
            item_valid_ff <= req_bus.valid;
         if (advance)
            result_valid_ff <= 1'b1;
         else if (rsp_bus.ready)
            result_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire)
         item_ff <= item_in;
      if (advance)
         result_ff <= result;
   end

   assign rsp_bus.valid     = result_valid_ff;
   assign rsp_bus.pin_level = result_ff.pin_level;
   assign rsp_bus.busy_res  = result_ff.busy_res;
   assign rsp_bus.status    = result_ff.status;

   // a held input beat stays put until the sequencer takes it
   a_item_hold: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff && $stable(item_ff))
      else $error("input beat lost or changed while waiting");

   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> item_valid_ff)
      else $error("accepted beat missing from input register");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> result_valid_ff)
      else $error("processed beat missing from result register");

   // range and suspend rejections come only from level updates
   a_status_src: assert property (@(posedge clock) disable iff (reset)
      advance && (result.status == ST_SUSP || result.status == ST_RANGE)
         |-> item_ff.opcode == OP_UPDATE)
      else $error("rejection status on a non-update beat");

endmodule
`default_nettype wire
